// ===== hdl/sbm_pkg.sv =====
// Shared types, constants and codes for the sliding window bitrate meter.
package sbm_pkg;

	localparam int FIFO_DEPTH_DEF = 64;
	localparam int LEN_BITS_DEF   = 20;

	localparam int FRAME_LEN_W = 20;
	localparam int TS_W        = 32;
	localparam int RATE_W      = 32;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int TOTAL_W     = 40;
	localparam int BYTE_SHIFT  = 3;
	localparam int DVD_W       = TOTAL_W + BYTE_SHIFT;

	localparam logic [CFG_W-1:0] MIN_DUR_RST = CFG_W'(200);
	localparam logic [CFG_W-1:0] QRY_WIN_RST = CFG_W'(1000);
	localparam logic [CFG_W-1:0] REC_WIN_RST = CFG_W'(2000);

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUR = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_QRY_WIN = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_REC_WIN = CFG_IDX_W'(2);

	localparam logic FUNC_RECORD = 1'b0;
	localparam logic FUNC_QUERY  = 1'b1;

	typedef struct packed {
		logic [CFG_W-1:0] min_dur;
		logic [CFG_W-1:0] qry_win;
		logic [CFG_W-1:0] rec_win;
	} cfg_t;

	typedef struct packed {
		logic push;
		logic pop;
	} fifo_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_sts_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_REC_EVICT,
		S_REC_WR,
		S_REC_WAIT,
		S_REC_CHK,
		S_QRY_START,
		S_QRY_DIV,
		S_QRY_WAIT,
		S_QRY_CHK,
		S_QRY_OUT
	} state_t;

endpackage

// ===== hdl/sbm_if.sv =====
// Valid/ready channel interfaces: frame requests, rate results, register writes.
interface sbm_in_if;
	logic                           valid;
	logic                           ready;
	logic                           func;
	logic [sbm_pkg::FRAME_LEN_W-1:0] frame_len;
	logic [sbm_pkg::TS_W-1:0]        now_ms;

	modport source (output valid, func, frame_len, now_ms, input ready);
	modport sink (input valid, func, frame_len, now_ms, output ready);
endinterface

interface sbm_out_if;
	logic                       valid;
	logic                       ready;
	logic [sbm_pkg::RATE_W-1:0] bitrate_kbps;

	modport source (output valid, bitrate_kbps, input ready);
	modport sink (input valid, bitrate_kbps, output ready);
endinterface

interface sbm_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [sbm_pkg::CFG_IDX_W-1:0] index;
	logic [sbm_pkg::CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/sbm_fifo.sv =====
// Circular frame FIFO: length and timestamp memory with registered head read.
module sbm_fifo #(
	parameter int FIFO_DEPTH = sbm_pkg::FIFO_DEPTH_DEF,
	parameter int LEN_BITS   = sbm_pkg::LEN_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sbm_pkg::fifo_cmd_t        cmd,
	input  logic [(LEN_BITS < sbm_pkg::FRAME_LEN_W ? LEN_BITS : sbm_pkg::FRAME_LEN_W)-1:0] wr_len,
	input  logic [sbm_pkg::TS_W-1:0]  wr_ts,
	output sbm_pkg::fifo_sts_t        sts,
	output logic [(LEN_BITS < sbm_pkg::FRAME_LEN_W ? LEN_BITS : sbm_pkg::FRAME_LEN_W)-1:0] rd_len,
	output logic [sbm_pkg::TS_W-1:0]  rd_ts
);
	localparam int LW = LEN_BITS < sbm_pkg::FRAME_LEN_W ? LEN_BITS : sbm_pkg::FRAME_LEN_W;
	localparam int EW = LW + sbm_pkg::TS_W;
	localparam int AW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	logic [EW-1:0] mem [FIFO_DEPTH];
	logic [EW-1:0] rd_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [CW:0]   tail_sum;
	logic [CW:0]   tail_wrap;
	logic [AW-1:0] tail;
	logic [AW-1:0] head_inc;

	always_comb begin
		tail_sum  = (CW+1)'(head_q) + (CW+1)'(count_q);
		tail_wrap = tail_sum >= (CW+1)'(FIFO_DEPTH) ? tail_sum - (CW+1)'(FIFO_DEPTH) : tail_sum;
		tail      = tail_wrap[AW-1:0];
		head_inc  = head_q == AW'(FIFO_DEPTH - 1) ? '0 : head_q + AW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.pop) begin
				head_q <= head_inc;
			end
			if (cmd.push && !cmd.pop) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop && !cmd.push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[tail] <= {wr_len, wr_ts};
		end
		rd_q <= mem[head_q];
	end

	assign sts.empty = count_q == '0;
	assign sts.full  = count_q == CW'(FIFO_DEPTH);
	assign rd_len    = rd_q[EW-1:sbm_pkg::TS_W];
	assign rd_ts     = rd_q[sbm_pkg::TS_W-1:0];

endmodule

// ===== hdl/sbm_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, saturating to 32 bits.
module sbm_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sbm_pkg::DVD_W-1:0]  dividend,
	input  logic [sbm_pkg::TS_W-1:0]   divisor,
	output logic                       busy,
	output logic                       done,
	output logic [sbm_pkg::RATE_W-1:0] quotient
);
	localparam int DW    = sbm_pkg::DVD_W;
	localparam int SW    = sbm_pkg::TS_W;
	localparam int CNT_W = $clog2(DW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SW-1:0]    rem_q;
	logic [DW-1:0]    quo_q;
	logic [SW-1:0]    dsr_q;
	logic [SW:0]      trial;
	logic             ge;
	logic [SW:0]      rem_nx;

	always_comb begin
		trial  = {rem_q, quo_q[DW-1]};
		ge     = trial >= {1'b0, dsr_q};
		rem_nx = ge ? trial - {1'b0, dsr_q} : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx[SW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = |quo_q[DW-1:sbm_pkg::RATE_W] ? '1 : quo_q[sbm_pkg::RATE_W-1:0];

endmodule

// ===== hdl/sbm_seq.sv =====
// Request sequencer: record/query steps, byte total, window start, rate output.
module sbm_seq #(
	parameter int LEN_BITS = sbm_pkg::LEN_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	sbm_in_if.sink                     item,
	sbm_out_if.source                  rate,
	input  sbm_pkg::cfg_t              cfg_regs,
	output sbm_pkg::fifo_cmd_t         fifo_cmd,
	input  sbm_pkg::fifo_sts_t         fifo_sts,
	output logic [(LEN_BITS < sbm_pkg::FRAME_LEN_W ? LEN_BITS : sbm_pkg::FRAME_LEN_W)-1:0] wr_len,
	output logic [sbm_pkg::TS_W-1:0]   wr_ts,
	input  logic [(LEN_BITS < sbm_pkg::FRAME_LEN_W ? LEN_BITS : sbm_pkg::FRAME_LEN_W)-1:0] rd_len,
	input  logic [sbm_pkg::TS_W-1:0]   rd_ts,
	output logic                       div_start,
	output logic [sbm_pkg::DVD_W-1:0]  div_dividend,
	output logic [sbm_pkg::TS_W-1:0]   div_divisor,
	input  logic                       div_done,
	input  logic [sbm_pkg::RATE_W-1:0] div_quotient
);
	localparam int LW = LEN_BITS < sbm_pkg::FRAME_LEN_W ? LEN_BITS : sbm_pkg::FRAME_LEN_W;
	localparam int TW = sbm_pkg::TOTAL_W;
	localparam int XW = sbm_pkg::TS_W - sbm_pkg::CFG_W;

	sbm_pkg::state_t           state_q, state_d;
	logic [LW-1:0]             len_q;
	logic [sbm_pkg::TS_W-1:0]  now_q;
	logic [TW-1:0]             total_q;
	logic [sbm_pkg::TS_W-1:0]  start_q;
	logic [sbm_pkg::RATE_W-1:0] rate_q;
	logic [sbm_pkg::RATE_W-1:0] out_q;
	logic                      out_valid_q;
	logic [sbm_pkg::TS_W-1:0]  sub_b;
	logic [sbm_pkg::TS_W-1:0]  diff;
	logic                      dur_ok;
	logic                      rec_drop;
	logic                      qry_drop;
	logic                      out_free;

	// shared subtract/compare: elapsed time or frame age
	always_comb begin
		sub_b    = state_q == sbm_pkg::S_QRY_START ? start_q : rd_ts;
		diff     = now_q - sub_b;
		dur_ok   = diff >= {{XW{1'b0}}, cfg_regs.min_dur} && diff != '0;
		rec_drop = !fifo_sts.empty && diff >= {{XW{1'b0}}, cfg_regs.rec_win};
		qry_drop = !fifo_sts.empty && diff >= {{XW{1'b0}}, cfg_regs.qry_win};
		out_free = !out_valid_q || rate.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		fifo_cmd   = '0;
		div_start  = 1'b0;
		item.ready = 1'b0;
		unique case (state_q)
			sbm_pkg::S_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					state_d = item.func == sbm_pkg::FUNC_QUERY ? sbm_pkg::S_QRY_START
						: sbm_pkg::S_REC_EVICT;
				end
			end
			sbm_pkg::S_REC_EVICT: begin
				fifo_cmd.pop = fifo_sts.full;
				state_d      = sbm_pkg::S_REC_WR;
			end
			sbm_pkg::S_REC_WR: begin
				fifo_cmd.push = 1'b1;
				state_d       = sbm_pkg::S_REC_WAIT;
			end
			sbm_pkg::S_REC_WAIT: begin
				state_d = sbm_pkg::S_REC_CHK;
			end
			sbm_pkg::S_REC_CHK: begin
				if (rec_drop) begin
					fifo_cmd.pop = 1'b1;
					state_d      = sbm_pkg::S_REC_WAIT;
				end else begin
					state_d = sbm_pkg::S_IDLE;
				end
			end
			sbm_pkg::S_QRY_START: begin
				if (dur_ok) begin
					div_start = 1'b1;
					state_d   = sbm_pkg::S_QRY_DIV;
				end else begin
					state_d = sbm_pkg::S_QRY_OUT;
				end
			end
			sbm_pkg::S_QRY_DIV: begin
				if (div_done) begin
					state_d = sbm_pkg::S_QRY_CHK;
				end
			end
			sbm_pkg::S_QRY_WAIT: begin
				state_d = sbm_pkg::S_QRY_CHK;
			end
			sbm_pkg::S_QRY_CHK: begin
				if (qry_drop) begin
					fifo_cmd.pop = 1'b1;
					state_d      = sbm_pkg::S_QRY_WAIT;
				end else begin
					state_d = sbm_pkg::S_QRY_OUT;
				end
			end
			sbm_pkg::S_QRY_OUT: begin
				if (out_free) begin
					state_d = sbm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sbm_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			start_q     <= '0;
			rate_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fifo_cmd.push) begin
				total_q <= total_q + TW'(len_q);
			end else if (fifo_cmd.pop) begin
				total_q <= total_q - TW'(rd_len);
			end
			if (fifo_cmd.pop && state_q == sbm_pkg::S_REC_CHK) begin
				start_q <= now_q;
			end else if (fifo_cmd.pop && state_q == sbm_pkg::S_QRY_CHK) begin
				start_q <= rd_ts;
			end
			if (state_q == sbm_pkg::S_QRY_DIV && div_done) begin
				rate_q <= div_quotient;
			end
			if (rate.valid && rate.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == sbm_pkg::S_QRY_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			len_q <= item.frame_len[LW-1:0];
			now_q <= item.now_ms;
		end
		if (state_q == sbm_pkg::S_QRY_OUT && out_free) begin
			out_q <= rate_q;
		end
	end

	assign wr_len            = len_q;
	assign wr_ts             = now_q;
	assign div_dividend      = {total_q, sbm_pkg::BYTE_SHIFT'(0)};
	assign div_divisor       = diff;
	assign rate.valid        = out_valid_q;
	assign rate.bitrate_kbps = out_q;

endmodule

// ===== hdl/sliding_window_bitrate_meter.sv =====
// Sliding window bitrate meter top level: register file, FIFO, divider, sequencer.
// One request at a time. A record steps through evict, write, wait and check, with a
// further wait and check for every frame aged out; a full FIFO evicts in a step that
// every record passes through, so it adds nothing. The FIFO memory has a registered
// read port, so each pop is followed by a read turnaround wait. A query goes straight
// to output when the window is too short to recompute; otherwise the 43-step serial
// divider runs, then a check and a wait per dropped frame, then output. The result
// sits in an output register, so the next request is taken while it waits to be read.
// Register writes are always accepted; indexes beyond the third register are ignored.
module sliding_window_bitrate_meter #(
	parameter int FIFO_DEPTH = sbm_pkg::FIFO_DEPTH_DEF,
	parameter int LEN_BITS   = sbm_pkg::LEN_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sbm_in_if.sink     item,
	sbm_out_if.source  rate,
	sbm_cfg_if.sink    cfg
);
	localparam int LW = LEN_BITS < sbm_pkg::FRAME_LEN_W ? LEN_BITS : sbm_pkg::FRAME_LEN_W;

	sbm_pkg::cfg_t             cfg_q;
	sbm_pkg::fifo_cmd_t        fifo_cmd;
	sbm_pkg::fifo_sts_t        fifo_sts;
	logic [LW-1:0]             wr_len;
	logic [sbm_pkg::TS_W-1:0]  wr_ts;
	logic [LW-1:0]             rd_len;
	logic [sbm_pkg::TS_W-1:0]  rd_ts;
	logic                      div_start;
	logic [sbm_pkg::DVD_W-1:0] div_dividend;
	logic [sbm_pkg::TS_W-1:0]  div_divisor;
	logic                      div_busy;
	logic                      div_done;
	logic [sbm_pkg::RATE_W-1:0] div_quotient;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_dur <= sbm_pkg::MIN_DUR_RST;
			cfg_q.qry_win <= sbm_pkg::QRY_WIN_RST;
			cfg_q.rec_win <= sbm_pkg::REC_WIN_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				sbm_pkg::CFG_MIN_DUR: cfg_q.min_dur <= cfg.data;
				sbm_pkg::CFG_QRY_WIN: cfg_q.qry_win <= cfg.data;
				sbm_pkg::CFG_REC_WIN: cfg_q.rec_win <= cfg.data;
				default: ;
			endcase
		end
	end

	sbm_fifo #(
		.FIFO_DEPTH (FIFO_DEPTH),
		.LEN_BITS   (LEN_BITS)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (fifo_cmd),
		.wr_len (wr_len),
		.wr_ts  (wr_ts),
		.sts    (fifo_sts),
		.rd_len (rd_len),
		.rd_ts  (rd_ts)
	);

	sbm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quotient)
	);

	sbm_seq #(
		.LEN_BITS (LEN_BITS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.rate         (rate),
		.cfg_regs     (cfg_q),
		.fifo_cmd     (fifo_cmd),
		.fifo_sts     (fifo_sts),
		.wr_len       (wr_len),
		.wr_ts        (wr_ts),
		.rd_len       (rd_len),
		.rd_ts        (rd_ts),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_done     (div_done),
		.div_quotient (div_quotient)
	);

	a_push_pop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(fifo_cmd.push && fifo_cmd.pop))
		else $error("fifo push and pop in the same cycle");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cmd.pop |-> !fifo_sts.empty)
		else $error("pop from empty fifo");

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> !item.ready)
		else $error("request taken while divider busy");

	a_accept_holds: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("ready held after request accepted");

endmodule

// ===== test/rate_checker.sv =====
// Checker for the bitrate meter: tracks the frame window, predicts each bitrate and compares.
module rate_checker
	import sbm_pkg::*;
#(
	parameter int DEPTH = FIFO_DEPTH_DEF,
	parameter int LEN_W = LEN_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	input  logic                   req_ready,
	input  logic                   req_func,
	input  logic [FRAME_LEN_W-1:0] req_len,
	input  logic [TS_W-1:0]        req_now,
	input  logic                   res_valid,
	input  logic                   res_ready,
	input  logic [RATE_W-1:0]      res_rate,
	input  logic                   wr_valid,
	input  logic                   wr_ready,
	input  logic [CFG_IDX_W-1:0]   wr_index,
	input  logic [CFG_W-1:0]       wr_data,
	output int                     errors,
	output int                     outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [FRAME_LEN_W-1:0] LEN_MASK = FRAME_LEN_W'((64'd1 << LEN_W) - 64'd1);
	localparam logic [DVD_W-1:0]       RATE_MAX = DVD_W'({RATE_W{1'b1}});

	logic [FRAME_LEN_W-1:0] frame_len_mem [DEPTH];
	logic [TS_W-1:0]        frame_ts_mem [DEPTH];
	int unsigned            head;
	int unsigned            count;
	logic [TOTAL_W-1:0]     byte_sum;
	logic [TS_W-1:0]        start_ms;
	logic [RATE_W-1:0]      rate_held;
	cfg_t                   regs;
	logic [RATE_W-1:0]      rate_q [$];

	function automatic void retire_oldest();
		byte_sum = byte_sum - TOTAL_W'(frame_len_mem[head]);
		head = (head + 1) % DEPTH;
		count--;
	endfunction

	function automatic logic [TS_W-1:0] oldest_age(input logic [TS_W-1:0] now);
		return now - frame_ts_mem[head];
	endfunction

	function automatic void log_frame(input logic [FRAME_LEN_W-1:0] len,
			input logic [TS_W-1:0] now);
		int unsigned tail;
		// full window: oldest frame goes first, start time untouched
		if (count >= DEPTH)
			retire_oldest();
		tail = (head + count) % DEPTH;
		frame_len_mem[tail] = len & LEN_MASK;
		frame_ts_mem[tail] = now;
		count++;
		byte_sum = byte_sum + TOTAL_W'(len & LEN_MASK);
		while (count > 0 && oldest_age(now) >= TS_W'(regs.rec_win)) begin
			retire_oldest();
			start_ms = now;
		end
	endfunction

	function automatic logic [RATE_W-1:0] rate_at(input logic [TS_W-1:0] now);
		logic [TS_W-1:0]  span;
		logic [DVD_W-1:0] quo;
		span = now - start_ms;
		if (span >= TS_W'(regs.min_dur) && span != '0) begin
			quo = (DVD_W'(byte_sum) << BYTE_SHIFT) / DVD_W'(span);
			rate_held = (quo > RATE_MAX) ? '1 : quo[RATE_W-1:0];
			while (count > 0 && oldest_age(now) >= TS_W'(regs.qry_win)) begin
				start_ms = frame_ts_mem[head];
				retire_oldest();
			end
		end
		return rate_held;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [RATE_W-1:0] want;
		if (!arst_n) begin
			head = 0;
			count = 0;
			byte_sum = '0;
			start_ms = '0;
			rate_held = '0;
			regs.min_dur = MIN_DUR_RST;
			regs.qry_win = QRY_WIN_RST;
			regs.rec_win = REC_WIN_RST;
			rate_q.delete();
			errors = 0;
			outstanding <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (rate_q.size() == 0) begin
					$display("%0t: unexpected bitrate %0d, no query pending", $time, res_rate);
					errors++;
				end else begin
					want = rate_q[0];
					rate_q.delete(0);
					if (res_rate !== want) begin
						$display("%0t: bitrate expected %0d, got %0d", $time, want, res_rate);
						errors++;
					end
				end
			end
			if (wr_valid && wr_ready) begin
				case (wr_index)
					CFG_MIN_DUR: regs.min_dur = wr_data;
					CFG_QRY_WIN: regs.qry_win = wr_data;
					CFG_REC_WIN: regs.rec_win = wr_data;
					default: ;
				endcase
			end
			if (req_valid && req_ready) begin
				if (req_func == FUNC_QUERY)
					rate_q.insert(rate_q.size(), rate_at(req_now));
				else
					log_frame(req_len, req_now);
			end
			outstanding <= rate_q.size();
		end
	end

endmodule

// ===== test/testbench.sv =====
// Top-level bench for the bitrate meter: clock, reset, request and register stimulus, verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sbm_pkg::*;

	localparam int SETTLE_CYCLES  = 300;
	localparam int HOLD_CYCLES    = 600;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 185;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);

	logic            clk;
	logic            arst_n;
	int              errors;
	int              outstanding;
	int unsigned     idle_pct;
	int unsigned     stall_pct;
	int unsigned     noise_pct;
	bit              hold_req;
	logic [TS_W-1:0] clock_ms;

	sbm_in_if  in_ch ();
	sbm_out_if out_ch ();
	sbm_cfg_if cfg_ch ();

	sliding_window_bitrate_meter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_ch),
		.rate   (out_ch),
		.cfg    (cfg_ch)
	);

	rate_checker #(
		.DEPTH (FIFO_DEPTH_DEF),
		.LEN_W (LEN_BITS_DEF)
	) chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (in_ch.valid),
		.req_ready   (in_ch.ready),
		.req_func    (in_ch.func),
		.req_len     (in_ch.frame_len),
		.req_now     (in_ch.now_ms),
		.res_valid   (out_ch.valid),
		.res_ready   (out_ch.ready),
		.res_rate    (out_ch.bitrate_kbps),
		.wr_valid    (cfg_ch.valid),
		.wr_ready    (cfg_ch.ready),
		.wr_index    (cfg_ch.index),
		.wr_data     (cfg_ch.data),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: random stalls, plus one long hold-off on demand
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic send_req(input logic f, input logic [FRAME_LEN_W-1:0] len,
			input logic [TS_W-1:0] t);
		int unsigned gap;
		gap = 0;
		while (idle_pct != 0 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.func      <= f;
		in_ch.frame_len <= len;
		in_ch.now_ms    <= t;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
	endtask

	// stop requests, wait out every pending bitrate, then extra cycles
	task automatic settle(input int extra);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
	endtask

	task automatic load_regs(input logic [CFG_W-1:0] md, input logic [CFG_W-1:0] qw,
			input logic [CFG_W-1:0] rw);
		settle(SETTLE_CYCLES);
		put_reg(CFG_MIN_DUR, md);
		put_reg(CFG_QRY_WIN, qw);
		put_reg(CFG_REC_WIN, rw);
		cfg_ch.valid <= 1'b0;
	endtask

	// mostly frames on an advancing clock; noise jumps the timestamp anywhere
	task automatic random_req(input int unsigned step_max);
		logic                   f;
		logic [FRAME_LEN_W-1:0] len;
		logic [TS_W-1:0]        t;
		int unsigned            roll;
		roll = $urandom_range(99);
		len = FRAME_LEN_W'($urandom);
		if ($urandom_range(15) == 0)
			len = $urandom_range(1) ? '1 : '0;
		if (roll < noise_pct) begin
			f = 1'($urandom_range(1));
			t = $urandom;
		end else begin
			clock_ms = clock_ms + $urandom_range(step_max);
			f = (roll < noise_pct + 24) ? FUNC_QUERY : FUNC_RECORD;
			t = clock_ms;
		end
		send_req(f, len, t);
	endtask

	initial begin
		int unsigned p;
		int unsigned n;
		int unsigned step_max;
		arst_n           <= 1'b0;
		in_ch.valid      <= 1'b0;
		in_ch.func       <= FUNC_RECORD;
		in_ch.frame_len  <= '0;
		in_ch.now_ms     <= '0;
		cfg_ch.valid     <= 1'b0;
		cfg_ch.index     <= CFG_MIN_DUR;
		cfg_ch.data      <= '0;
		idle_pct  = 0;
		stall_pct = 0;
		noise_pct = 0;
		hold_req  = 1'b0;
		clock_ms  = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: short window, aging out, timestamp wrap
		send_req(FUNC_QUERY, '0, '0);
		send_req(FUNC_RECORD, '1, 32'd100);
		send_req(FUNC_RECORD, '0, 32'd150);
		send_req(FUNC_QUERY, '0, 32'd150);
		send_req(FUNC_QUERY, '1, 32'd300);
		send_req(FUNC_RECORD, 20'd12345, 32'd2500);
		send_req(FUNC_QUERY, '0, 32'd2700);
		send_req(FUNC_RECORD, 20'd7, 32'hFFFF_FF00);
		send_req(FUNC_RECORD, 20'd1, 32'h0000_0040);
		send_req(FUNC_QUERY, '0, '1);

		// zero windows drop even the new frame; zero duration skips the recompute
		load_regs('0, '0, '0);
		send_req(FUNC_RECORD, 20'd500, 32'd1000);
		send_req(FUNC_QUERY, '0, 32'd1000);
		send_req(FUNC_QUERY, '0, 32'd1005);
		send_req(FUNC_RECORD, 20'hAAAAA, 32'h5555_5555);

		load_regs('1, '1, '1);
		send_req(FUNC_RECORD, 20'h55555, 32'h0001_0000);
		send_req(FUNC_RECORD, '1, 32'h0001_0010);
		send_req(FUNC_QUERY, '0, 32'h0001_0020);
		send_req(FUNC_QUERY, '0, 32'h0002_0000);

		// unused register index must change nothing
		settle(SETTLE_CYCLES);
		put_reg(CFG_UNUSED, '1);
		cfg_ch.valid <= 1'b0;

		load_regs(16'd1, 16'd1, 16'd1);
		send_req(FUNC_RECORD, 20'd3, 32'd10);
		send_req(FUNC_RECORD, 20'd4, 32'd10);
		send_req(FUNC_QUERY, '0, 32'd11);

		for (p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 61;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 61;
				end
				default: begin
					idle_pct = 17;
					stall_pct = 17;
				end
			endcase
			noise_pct = (p % 3 == 1) ? 6 : 0;
			case (p)
				0, 5: begin
					load_regs(MIN_DUR_RST, QRY_WIN_RST, REC_WIN_RST);
					step_max = $urandom_range(5, 30);
				end
				2: begin
					load_regs('1, '1, '1);
					step_max = 40;
				end
				3: begin
					load_regs(16'd1, 16'd1, 16'd1);
					step_max = 3;
				end
				default: begin
					load_regs(CFG_W'($urandom_range(1, 500)), CFG_W'($urandom_range(1, 3000)),
						CFG_W'($urandom_range(1, 5000)));
					step_max = $urandom_range(1, 60);
				end
			endcase
			clock_ms = $urandom;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n == 30)
					hold_req = 1'b1;
				if (n == 120)
					settle(0);
				random_req(step_max);
			end
		end

		settle(SETTLE_CYCLES);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
